@@ src/assert_macros.svh @@
// Assertion macros for the blocklist RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define TABL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define TABL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

@@ src/tabl_pkg.sv @@
// Types and constants shared by the timed address blocklist modules.
package tabl_pkg;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_CHECK   = 2'd1;
    localparam logic [1:0] MODE_EXCLUDE = 2'd2;

    localparam logic [15:0] BAN_DURATION_RESET = 16'd60;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
    } t_in;

    typedef struct packed {
        logic       is_banned;
        logic       table_full;
        logic [5:0] slot_used;
        logic [6:0] released_count;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [15:0] remaining;
        logic [31:0] address;
    } t_entry;

    // Verdict of the entry unit on one table entry.
    typedef struct packed {
        logic   hit;
        logic   free;
        logic   release_entry;
        logic   wr_en;
        t_entry wr_entry;
    } t_eval;

endpackage

@@ src/timed_address_blocklist_core.sv @@
// Every beat on the input names a tick, a check, an exclude or the unused mode, and gives
// exactly one result beat. The table sits in a single-port-read memory that is walked one
// entry per cycle through a shared entry unit, so a tick, a check that misses or an exclude
// into a full table walks every entry before the result register is loaded; a check that
// hits or an exclude that finds a free slot stops at that slot, and the unused mode goes
// straight to the result register. A finished result waits while the previous one is still
// held in the result register. The input is ready again once the result is registered.
// One beat is worked on at a time, and the input is not ready meanwhile. After reset a
// clearing pass marks every entry free before the first beat is taken; ban_duration writes
// are taken at any time.
`include "assert_macros.svh"

module timed_address_blocklist_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tabl_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tabl_pkg::t_out  o_out_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] IDX_LAST = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] IDX_END  = CW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DRAIN} t_state;

    t_state           r_state;
    logic [CW-1:0]    r_idx;
    logic             r_pend;
    logic [IW-1:0]    r_pidx;
    logic [1:0]       r_mode;
    logic [31:0]      r_addr;
    logic [CW-1:0]    r_count;
    logic             r_banned;
    logic             r_full;
    logic [IW-1:0]    r_slot;
    logic [15:0]      r_ban_duration;
    logic             r_out_valid;
    tabl_pkg::t_out   r_out_data;
    tabl_pkg::t_out   n_out_data;

    logic             rd_en;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    tabl_pkg::t_entry wr_data;
    tabl_pkg::t_entry rd_data;
    tabl_pkg::t_eval  ev;
    logic [IW+5:0]    slot_ext;
    logic [CW+6:0]    count_ext;

    tabl_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (rd_data)
    );

    tabl_eval u_eval (
        .i_mode         (r_mode),
        .i_address      (r_addr),
        .i_ban_duration (r_ban_duration),
        .i_entry        (rd_data),
        .o_eval         (ev)
    );

    // A read is issued at r_idx; its data, for slot r_pidx, is seen in the next cycle.
    assign rd_en = (r_state == S_SCAN) && (r_idx != IDX_END);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = ev.wr_entry;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[IW-1:0];
            wr_data = '0;
        end else if (r_state == S_SCAN) begin
            wr_en = r_pend && ev.wr_en;
        end
    end

    assign slot_ext  = {6'd0, r_slot};
    assign count_ext = {7'd0, r_count};

    always_comb begin
        n_out_data                = '0;
        n_out_data.is_banned      = r_banned;
        n_out_data.table_full     = r_full;
        n_out_data.slot_used      = slot_ext[5:0];
        n_out_data.released_count = count_ext[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ban_duration <= tabl_pkg::BAN_DURATION_RESET;
        end else if (i_cfg_wr_en) begin
            r_ban_duration <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the drain state the result register is handled below.
            if (r_out_valid && i_out_ready && r_state != S_DRAIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode   <= i_in_data.mode;
                        r_addr   <= i_in_data.address;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_count  <= '0;
                        r_banned <= 1'b0;
                        r_full   <= 1'b0;
                        r_slot   <= '0;
                        if (i_in_data.mode == tabl_pkg::MODE_TICK ||
                            i_in_data.mode == tabl_pkg::MODE_CHECK ||
                            i_in_data.mode == tabl_pkg::MODE_EXCLUDE) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_SCAN: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_idx  <= r_idx + CW'(1);
                        r_pidx <= r_idx[IW-1:0];
                    end
                    if (r_pend) begin
                        if (ev.release_entry) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (ev.hit) begin
                            r_banned <= 1'b1;
                            r_state  <= S_DRAIN;
                        end
                        if (ev.free) begin
                            r_slot  <= r_pidx;
                            r_state <= S_DRAIN;
                        end
                    end else if (!rd_en) begin
                        // Walked the whole table without an early stop.
                        r_full  <= (r_mode == tabl_pkg::MODE_EXCLUDE);
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= n_out_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `TABL_ASSERT(a_no_beat_during_clear, i_clk, i_rst_n,
        $past(!i_rst_n) |-> !o_in_ready, "input ready during clearing pass")
    `TABL_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> !o_in_ready,
        "input ready right after a beat was accepted")
    `TABL_ASSERT(a_no_write_when_idle, i_clk, i_rst_n,
        (r_state == S_IDLE || r_state == S_DRAIN) |-> !wr_en,
        "table written outside scan or clear")
    `TABL_ASSERT(a_result_fields_exclusive, i_clk, i_rst_n,
        o_out_valid |-> !(o_out_data.is_banned && o_out_data.table_full),
        "result flags both banned and full")

endmodule

@@ src/tabl_mem.sv @@
// Entry table memory: one write port and one registered read port.
module tabl_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  tabl_pkg::t_entry      i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output tabl_pkg::t_entry      o_rd_data
);

    tabl_pkg::t_entry r_mem [DEPTH];
    tabl_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/tabl_eval.sv @@
// Entry unit: compares, allocates or counts down one table entry per cycle.
module tabl_eval (
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_address,
    input  logic [15:0]       i_ban_duration,
    input  tabl_pkg::t_entry  i_entry,
    output tabl_pkg::t_eval   o_eval
);

    always_comb begin
        o_eval          = '0;
        o_eval.wr_entry = i_entry;
        unique case (i_mode)
            tabl_pkg::MODE_TICK: begin
                o_eval.wr_en = i_entry.valid;
                if (i_entry.remaining <= 16'd1) begin
                    o_eval.release_entry      = i_entry.valid;
                    o_eval.wr_entry.valid     = 1'b0;
                    o_eval.wr_entry.remaining = '0;
                end else begin
                    o_eval.wr_entry.remaining = i_entry.remaining - 16'd1;
                end
            end
            tabl_pkg::MODE_CHECK: begin
                o_eval.hit = i_entry.valid && (i_entry.address == i_address);
            end
            tabl_pkg::MODE_EXCLUDE: begin
                o_eval.free               = !i_entry.valid;
                o_eval.wr_en              = !i_entry.valid;
                o_eval.wr_entry.valid     = 1'b1;
                o_eval.wr_entry.remaining = i_ban_duration;
                o_eval.wr_entry.address   = i_address;
            end
            default: begin
            end
        endcase
    end

endmodule
